// ----- hdl/key_hit_history_tracker_defines.svh -----
// Assertion macros shared by the key hit history tracker RTL.
`ifndef KEY_HIT_HISTORY_TRACKER_DEFINES_SVH
`define KEY_HIT_HISTORY_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, idle during reset.
`define KHHT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("key hit history tracker: assertion failed");
// Next-cycle implication, sampled on clk, idle during reset.
`define KHHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("key hit history tracker: assertion failed");
`else
`define KHHT_ASSERT_NOW(label, ante, cons)
`define KHHT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/khht_pkg.sv -----
// Shared constants, opcodes and types of the key hit history tracker.
`default_nettype none
package khht_pkg;

	localparam int HISTORY_DEPTH = 8;
	localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
	localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int AGE_W         = 16;
	localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

	localparam logic [1:0] OP_HIT    = 2'd0;
	localparam logic [1:0] OP_ELAPSE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	typedef struct packed {
		logic [7:0]       led;
		logic [7:0]       x;
		logic [7:0]       y;
		logic [AGE_W-1:0] age;
	} entry_t;

	typedef struct packed {
		logic             shift;
		logic             load;
		logic             age_en;
		logic [AGE_W-1:0] delta;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/khht_cell.sv -----
// One history cell: holds an entry, shifts from its neighbour, ages and passes the count on.
`default_nettype none
module khht_cell
	import khht_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_ctrl_t       ctrl,
	input  wire entry_t           new_entry,
	input  wire entry_t           next_entry,
	input  wire logic [CNT_W-1:0] cnt_in,
	output logic [CNT_W-1:0]      cnt_out,
	output entry_t                entry
);

	entry_t           entry_q;
	entry_t           entry_d;
	logic [AGE_W:0]   age_sum;
	logic             age_ovf;

	assign age_sum = {1'b0, entry_q.age} + {1'b0, ctrl.delta};
	assign age_ovf = age_sum[AGE_W];

	always_comb begin
		entry_d = entry_q;
		if (ctrl.load) begin
			entry_d = new_entry;
		end else if (ctrl.shift) begin
			entry_d = next_entry;
		end else if (ctrl.age_en && !age_ovf) begin
			entry_d.age = age_sum[AGE_W-1:0];
		end
	end

	// an expiring entry keeps its age but leaves the live count
	assign cnt_out = cnt_in - CNT_W'(ctrl.age_en && age_ovf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '{led: 8'd0, x: 8'd0, y: 8'd0, age: AGE_MAX};
		end else begin
			entry_q <= entry_d;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

// ----- hdl/key_hit_history_tracker.sv -----
// Top level of the key hit history tracker: cell chain, live count and result register.
// The tracker keeps the most recent HISTORY_DEPTH key hits, one per cell of a chain,
// each with LED index, x/y position and a 16-bit age. Per accepted input transaction,
// a hit appends at the live count, or shifts the whole chain down one cell and
// enters at the top when the history is full; an elapse adds the tick count to every
// live cell in parallel, and each cell that would pass 65535 keeps its age and takes one
// off the live count as the count ripples along the chain; a read selects one cell. The
// result transaction (live count, plus the read entry or zeros) sits in an output
// register in the cycle after acceptance, and a new input is accepted in the same cycle as
// that result is taken, so one transaction per cycle is sustained without output stall.
// Reset empties the count and sets every cell to LED 0, position 0, age 65535 at once.
`default_nettype none
`include "key_hit_history_tracker_defines.svh"
module key_hit_history_tracker
	import khht_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic        hit_valid,
	input  wire logic [7:0]  led_number,
	input  wire logic [7:0]  pos_x,
	input  wire logic [7:0]  pos_y,
	input  wire logic [15:0] elapsed,
	input  wire logic [2:0]  read_slot,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       hit_count,
	output logic [7:0]       out_led,
	output logic [7:0]       out_x,
	output logic [7:0]       out_y,
	output logic [15:0]      out_age
);

	logic             in_acc;
	logic             do_hit;
	logic             do_age;
	logic             do_read;
	logic             full;
	logic [CNT_W-1:0] live_q;
	logic [CNT_W-1:0] live_d;
	logic             out_valid_q;
	logic [3:0]       hit_count_q;
	entry_t           rd_q;
	entry_t           rd_d;
	entry_t           new_entry;
	entry_t           entries   [HISTORY_DEPTH];
	cell_ctrl_t       ctrl      [HISTORY_DEPTH];
	logic [CNT_W-1:0] cnt_chain [HISTORY_DEPTH+1];
	logic [SLOT_W-1:0] rd_idx;
	logic             rd_in_range;

	// take a new transaction whenever the result register is empty or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		do_hit  = 1'b0;
		do_age  = 1'b0;
		do_read = 1'b0;
		case (opcode)
			OP_HIT:    do_hit  = in_acc && hit_valid;
			OP_ELAPSE: do_age  = in_acc;
			OP_READ:   do_read = in_acc;
			default:   do_hit  = 1'b0;
		endcase
	end

	assign full      = (live_q >= CNT_W'(HISTORY_DEPTH));
	assign new_entry = '{led: led_number, x: pos_x, y: pos_y, age: '0};

	// the count enters the chain at cell 0 and each expiring live cell takes one off
	assign cnt_chain[0] = live_q;

	for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
		always_comb begin
			ctrl[k].delta  = elapsed;
			ctrl[k].age_en = do_age && (CNT_W'(k) < live_q);
			if (k == HISTORY_DEPTH - 1) begin
				// top cell takes the new hit when full, so it never shifts
				ctrl[k].shift = 1'b0;
				ctrl[k].load  = do_hit && (full || (live_q == CNT_W'(k)));
			end else begin
				ctrl[k].shift = do_hit && full;
				ctrl[k].load  = do_hit && !full && (live_q == CNT_W'(k));
			end
		end

		if (k == HISTORY_DEPTH - 1) begin : g_top
			khht_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl[k]),
				.new_entry  (new_entry),
				.next_entry (new_entry),
				.cnt_in     (cnt_chain[k]),
				.cnt_out    (cnt_chain[k+1]),
				.entry      (entries[k])
			);
		end else begin : g_mid
			khht_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl[k]),
				.new_entry  (new_entry),
				.next_entry (entries[k+1]),
				.cnt_in     (cnt_chain[k]),
				.cnt_out    (cnt_chain[k+1]),
				.entry      (entries[k])
			);
		end
	end

	// advance the live count: saturate at the depth on hits, take the chain's tail on elapse
	always_comb begin
		live_d = live_q;
		if (do_hit) begin
			live_d = full ? CNT_W'(HISTORY_DEPTH) : live_q + CNT_W'(1);
		end else if (do_age) begin
			live_d = cnt_chain[HISTORY_DEPTH];
		end
	end

	// read selection: a slot beyond the depth reads as zeros
	assign rd_in_range = (int'(read_slot) < HISTORY_DEPTH);
	assign rd_idx      = SLOT_W'(read_slot);

	always_comb begin
		rd_d = '0;
		if (do_read && rd_in_range) begin
			rd_d = entries[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			live_q <= live_d;
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result payload until the next accepted transaction replaces it
	always_ff @(posedge clk) begin
		if (in_acc) begin
			hit_count_q <= 4'(live_d);
			rd_q        <= rd_d;
		end
	end

	assign out_valid = out_valid_q;
	assign hit_count = hit_count_q;
	assign out_led   = rd_q.led;
	assign out_x     = rd_q.x;
	assign out_y     = rd_q.y;
	assign out_age   = rd_q.age;

	`KHHT_ASSERT_NOW(a_count_bounded, 1'b1, live_q <= CNT_W'(HISTORY_DEPTH))
	`KHHT_ASSERT_NEXT(a_hit_grows, do_hit, live_q == ($past(full) ? CNT_W'(HISTORY_DEPTH) : $past(live_q) + CNT_W'(1)))
	`KHHT_ASSERT_NEXT(a_elapse_no_growth, do_age, live_q <= $past(live_q))
	`KHHT_ASSERT_NEXT(a_read_keeps_count, do_read, $stable(live_q))

endmodule
`default_nettype wire
